// File: rtl/idb_pkg.sv
// ----------------------------------------------------------------------------
// idb_pkg: shared types for the indexed deque buffer
// Operation and status codes, fixed field widths and the command bundle
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package idb_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 4;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_WRITE      = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic load;  // capture the request fields
    logic exec;  // apply the operation, write the store, move the pointers
    logic look;  // fetch front and back entries, capture the indexed read
  } ctl_cmd_t;

endpackage

// File: rtl/idb_ram.sv
// ----------------------------------------------------------------------------
// idb_ram: generic storage array
// One write port and two read ports, each read registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module idb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                       rdata_a,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                       rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/idb_ctrl.sv
// ----------------------------------------------------------------------------
// idb_ctrl: sequencing state machine
// Walks each request through execute, lookup and finish steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module idb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output idb_pkg::ctl_cmd_t cmd
);

  import idb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_LOOK = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // The finish step only presents the result, so a new request may enter there.
  assign busy     = (state == S_EXEC) || (state == S_LOOK);
  assign done     = (state == S_FIN);
  assign cmd.load = start && !busy;
  assign cmd.exec = (state == S_EXEC);
  assign cmd.look = (state == S_LOOK);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_LOOK;
      end
      S_LOOK: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        state_next = start ? S_EXEC : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_exec_then_look: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> cmd.look)
    else $error("execute step not followed by lookup");

  a_look_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.look |=> done)
    else $error("lookup step not followed by result strobe");

endmodule

// File: rtl/idb_datapath.sv
// ----------------------------------------------------------------------------
// idb_datapath: ring pointers, entry store and result formation
// Holds the front slot and entry count and drives the store's ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module idb_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  idb_pkg::ctl_cmd_t                    cmd,
  input  logic [idb_pkg::OP_W-1:0]             operation,
  input  logic [idb_pkg::POS_W-1:0]            position,
  input  logic signed [idb_pkg::DATA_W-1:0]    value,
  output logic [idb_pkg::STAT_W-1:0]           status,
  output logic signed [idb_pkg::DATA_W-1:0]    read_value,
  output logic [$clog2(CAPACITY+1)-1:0]        count,
  output logic signed [idb_pkg::DATA_W-1:0]    front_value,
  output logic signed [idb_pkg::DATA_W-1:0]    back_value,
  output logic                                 is_empty
);

  import idb_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int SW   = CW + 1;
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // Slot of the entry at a given offset from the front; the sum stays below
  // twice the capacity, so one conditional subtract wraps it.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] offs);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(offs);
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  op_t                op_q;
  logic [POS_W-1:0]   pos_q;
  logic [DATA_W-1:0]  val_q;
  logic [AW-1:0]      front;
  logic [CW-1:0]      cnt;
  status_t            status_q;
  logic               rd_ok;
  logic [DATA_W-1:0]  rd_q;

  status_t            status_next;
  logic [AW-1:0]      front_next;
  logic [CW-1:0]      cnt_next;
  logic               rd_ok_next;
  logic               wr_req;
  logic [AW-1:0]      wr_slot;

  logic               full;
  logic               empty;
  logic               in_range;
  logic [AW-1:0]      slot_tail;
  logic [AW-1:0]      slot_pos;
  logic [AW-1:0]      slot_second;
  logic [AW-1:0]      slot_last;
  logic [AW-1:0]      front_dec;

  logic               ram_we;
  logic [AW-1:0]      raddr_a;
  logic [DATA_W-1:0]  rdata_a;
  logic [DATA_W-1:0]  rdata_b;

  assign full        = (cnt == CW'(CAPACITY));
  assign empty       = (cnt == '0);
  assign in_range    = (CMPW'(pos_q) < CMPW'(cnt));
  assign slot_tail   = slot_of(front, cnt);
  assign slot_pos    = slot_of(front, CW'(pos_q));
  assign slot_second = slot_of(front, CW'(1));
  assign slot_last   = slot_of(front, cnt - CW'(1));
  assign front_dec   = (front == '0) ? AW'(CAPACITY - 1) : front - AW'(1);

  always_comb begin
    status_next = ST_OK;
    front_next  = front;
    cnt_next    = cnt;
    rd_ok_next  = 1'b0;
    wr_req      = 1'b0;
    wr_slot     = slot_tail;
    case (op_q)
      OP_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          wr_req   = 1'b1;
          wr_slot  = slot_tail;
          cnt_next = cnt + CW'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          wr_req     = 1'b1;
          wr_slot    = front_dec;
          front_next = front_dec;
          cnt_next   = cnt + CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          cnt_next = cnt - CW'(1);
          // The last entry leaving keeps the front slot where it was.
          if (cnt != CW'(1)) begin
            front_next = slot_second;
          end
        end
      end
      OP_READ: begin
        if (in_range) begin
          rd_ok_next = 1'b1;
        end else begin
          status_next = ST_RANGE;
        end
      end
      OP_WRITE: begin
        if (in_range) begin
          wr_req  = 1'b1;
          wr_slot = slot_pos;
        end else begin
          status_next = ST_RANGE;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // The indexed read is issued in the execute step; the front and back reads
  // follow in the lookup step, after any write has landed.
  assign ram_we  = cmd.exec && wr_req;
  assign raddr_a = cmd.exec ? slot_pos : front;

  idb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (wr_slot),
    .wdata   (val_q),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (slot_last),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      cnt   <= '0;
    end else if (cmd.exec) begin
      front <= front_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op_t'(operation);
      pos_q <= position;
      val_q <= value;
    end
    if (cmd.exec) begin
      status_q <= status_next;
      rd_ok    <= rd_ok_next;
    end
    if (cmd.look) begin
      rd_q <= rd_ok ? rdata_a : '0;
    end
  end

  assign status      = status_q;
  assign read_value  = rd_q;
  assign count       = cnt;
  assign is_empty    = empty;
  assign front_value = empty ? '0 : rdata_a;
  assign back_value  = empty ? '0 : rdata_b;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && full &&
     (op_q == OP_PUSH_BACK || op_q == OP_PUSH_FRONT)) |=>
    (cnt == $past(cnt) && front == $past(front)))
    else $error("push into a full store changed the pointers");

endmodule

// File: rtl/indexed_deque_buffer.sv
// ----------------------------------------------------------------------------
// indexed_deque_buffer: bounded double-ended queue in a ring store
// A request is transferred at a rising edge where start is high and busy is
// low. It carries an operation (push back, push front, pop back, pop front,
// read at index, write at index), a position counted from the front and a
// value. Each request yields exactly one result, presented for a single
// cycle while done is high: a status code, the value read, the entry count,
// the front and back entries (zero when empty) and an empty flag, all taken
// after the operation. The receiver cannot stall; it must take the result
// in the cycle that done is high.
// Sequence: after the request transfer, an execute step applies the
// operation and writes the store, a lookup step reads the front and back
// entries from the two read ports of the store, and done is high in the
// finish step that follows. A new request may be transferred at the edge
// that ends the done cycle, not while one is in its execute or lookup step;
// the store's registered read following its write sets these steps.
// Reset (rst, synchronous) empties the queue at once; no clearing pass runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_deque_buffer #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [idb_pkg::OP_W-1:0]          operation,
  input  logic [idb_pkg::POS_W-1:0]         position,
  input  logic signed [idb_pkg::DATA_W-1:0] value,
  output logic                              done,
  output logic [idb_pkg::STAT_W-1:0]        status,
  output logic signed [idb_pkg::DATA_W-1:0] read_value,
  output logic [$clog2(CAPACITY+1)-1:0]     count,
  output logic signed [idb_pkg::DATA_W-1:0] front_value,
  output logic signed [idb_pkg::DATA_W-1:0] back_value,
  output logic                              is_empty
);

  import idb_pkg::*;

  // Command bundle from the sequencer to the datapath. The datapath needs no
  // status back, since every operation takes the same number of steps.
  ctl_cmd_t cmd;

  idb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // The datapath keeps the front slot and entry count, owns the ring store
  // and forms the result fields, which stay steady through the done cycle.
  idb_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .operation   (operation),
    .position    (position),
    .value       (value),
    .status      (status),
    .read_value  (read_value),
    .count       (count),
    .front_value (front_value),
    .back_value  (back_value),
    .is_empty    (is_empty)
  );

endmodule
